/* hdl/utf16le_to_utf8_transcoder_unit_assert.svh */
// Assertion macros for the transcoder RTL.
`ifndef UTF16LE_TO_UTF8_TRANSCODER_UNIT_ASSERT_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U16U8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transcoder assertion failed");

// Next-cycle implication, checked out of reset.
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

`endif

/* hdl/u16u8_pkg.sv */
// Types, constants and UTF-8 encode helpers for the UTF-16LE to UTF-8 transcoder.
package u16u8_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [15:0] UNIT_BOM       = 16'hFEFF;
    localparam logic [15:0] UNIT_HIGH_MIN  = 16'hD800;
    localparam logic [15:0] UNIT_HIGH_MAX  = 16'hDBFF;
    localparam logic [15:0] UNIT_LOW_MIN   = 16'hDC00;
    localparam logic [15:0] UNIT_LOW_MAX   = 16'hDFFF;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_MAX_1BYTE   = 21'h00007F;
    localparam logic [20:0] CP_MAX_2BYTE   = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3BYTE   = 21'h00FFFF;
    localparam logic [7:0]  LEAD_2BYTE     = 8'hC0;
    localparam logic [7:0]  LEAD_3BYTE     = 8'hE0;
    localparam logic [7:0]  LEAD_4BYTE     = 8'hF0;
    localparam logic [7:0]  CONT_BYTE      = 8'h80;

    // Work for one accepted unit: up to two code points, packed toward slot 0.
    typedef struct packed {
        logic        cp0_v;
        logic [20:0] cp0;
        logic        cp1_v;
        logic [20:0] cp1;
        logic        ended;
    } t_desc;

    // Index of the final UTF-8 byte of a code point (length minus one).
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp <= CP_MAX_1BYTE) begin
            r = 2'd0;
        end else if (cp <= CP_MAX_2BYTE) begin
            r = 2'd1;
        end else if (cp <= CP_MAX_3BYTE) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        b = CONT_BYTE | {2'b00, cp[5:0]};
        case (utf8_last_idx(cp))
            2'd0: b = cp[7:0];
            2'd1: begin
                if (idx == 2'd0) b = LEAD_2BYTE | {3'b000, cp[10:6]};
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = LEAD_3BYTE | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = LEAD_4BYTE | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

/* hdl/utf16le_to_utf8_transcoder_unit.sv */
// Top level of the UTF-16LE to UTF-8 transcoder.
//
//   chan | handshake                 | fields
//   -----+---------------------------+---------------------------------------------------------
//   in   | i_in_valid / o_in_stall   | i_code_unit, i_first_unit, i_last_unit
//   out  | o_out_valid / i_out_stall | o_out_byte, o_byte_valid, o_last_of_run, o_end_of_string
//
// One byte leaves per cycle through the output register while i_out_stall is low, and a unit
// yields 1 to 6 results (typically 1 to 4); a unit with no result still takes an input slot.
// A unit can be accepted every cycle while the descriptor queue has room; its first byte
// passes the queue, the work register and the output register. Reset is synchronous and clears
// surrogate, end and queue state; no clearing pass. o_in_stall rises only when the queue is full.
module utf16le_to_utf8_transcoder_unit
    import u16u8_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_first_unit,
    input  logic        i_last_unit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_end_of_string
);

`include "utf16le_to_utf8_transcoder_unit_assert.svh"

    logic  accept;
    logic  q_push, q_pop, q_full, q_empty;
    t_desc f_desc, q_desc;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_code_unit  (i_code_unit),
        .i_first_unit (i_first_unit),
        .i_last_unit  (i_last_unit),
        .o_push       (q_push),
        .o_desc       (f_desc)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (f_desc),
        .i_pop   (q_pop),
        .o_desc  (q_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u16u8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_desc          (q_desc),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string)
    );

    `U16U8_ASSERT_NOW(a_eos_closes_run, i_clk, i_rst_n,
        o_out_valid && o_end_of_string, o_last_of_run)
    `U16U8_ASSERT_NOW(a_marker_only_at_end, i_clk, i_rst_n,
        o_out_valid && !o_byte_valid, o_end_of_string && (o_out_byte == 8'd0))
    `U16U8_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_empty)
    `U16U8_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, q_push && !q_pop, !q_empty)

endmodule

/* hdl/u16u8_front.sv */
// Front end: accepts code units, tracks surrogate and end state, builds descriptors.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [15:0] i_code_unit,
    input  logic        i_first_unit,
    input  logic        i_last_unit,
    output logic        o_push,
    output t_desc       o_desc
);

    logic       r_held_valid, n_held_valid;
    logic [9:0] r_held_bits, n_held_bits;
    logic       r_stopped, n_stopped;

    logic       held_v;
    logic [9:0] held_bits;
    logic       stopped;
    logic       is_low, is_high, is_bom;
    logic       flush;
    logic       x_v;
    logic [20:0] x_cp;
    logic       ended;

    always_comb begin
        held_v    = r_held_valid & ~i_first_unit;
        held_bits = i_first_unit ? 10'd0 : r_held_bits;
        stopped   = r_stopped & ~i_first_unit;
        is_low    = (i_code_unit >= UNIT_LOW_MIN) && (i_code_unit <= UNIT_LOW_MAX);
        is_high   = (i_code_unit >= UNIT_HIGH_MIN) && (i_code_unit <= UNIT_HIGH_MAX);
        is_bom    = i_first_unit && (i_code_unit == UNIT_BOM);

        flush        = 1'b0;
        x_v          = 1'b0;
        x_cp         = CP_REPLACEMENT;
        ended        = i_last_unit;
        n_held_valid = 1'b0;
        n_held_bits  = 10'd0;

        if (is_bom) begin
            // mark skipped, nothing to encode
        end else if (held_v && is_low) begin
            x_v  = 1'b1;
            x_cp = CP_SUPP_BASE + {1'b0, held_bits, i_code_unit[9:0]};
        end else begin
            flush = held_v;
            if (i_code_unit == 16'd0) begin
                ended = 1'b1;
            end else if (is_high) begin
                // a high surrogate still open at the buffer end becomes U+FFFD
                if (i_last_unit) begin
                    x_v = 1'b1;
                end else begin
                    n_held_valid = 1'b1;
                    n_held_bits  = i_code_unit[9:0];
                end
            end else if (is_low) begin
                x_v = 1'b1;
            end else begin
                x_v  = 1'b1;
                x_cp = {5'd0, i_code_unit};
            end
        end

        n_stopped = ended;
        if (stopped) begin
            n_held_valid = held_v;
            n_held_bits  = held_bits;
            n_stopped    = 1'b1;
        end

        o_desc.cp0_v = flush | x_v;
        o_desc.cp0   = flush ? CP_REPLACEMENT : x_cp;
        o_desc.cp1_v = flush & x_v;
        o_desc.cp1   = x_cp;
        o_desc.ended = ended;
        o_push       = i_accept && !stopped && (flush || x_v || ended);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= 10'd0;
            r_stopped    <= 1'b0;
        end else if (i_accept) begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
            r_stopped    <= n_stopped;
        end
    end

endmodule

/* hdl/u16u8_queue.sv */
// Small descriptor queue between the front and back ends.
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_full,
    output logic  o_empty
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_desc           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/u16u8_back.sv */
// Back end: walks each descriptor and sends one UTF-8 byte per cycle unless the output is stalled.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_desc      i_desc,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic       o_end_of_string
);

    t_desc       r_work;
    logic        r_w_valid;
    logic        r_sel;
    logic [1:0]  r_idx;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_byte_valid;
    logic        r_last_of_run;
    logic        r_end_of_string;

    logic        can_emit, emit, done, load;
    logic [20:0] cur_cp;
    logic        cp_last;
    logic [7:0]  cur_byte;

    always_comb begin
        can_emit = !r_out_valid || !i_out_stall;
        emit     = can_emit && r_w_valid;
        cur_cp   = r_sel ? r_work.cp1 : r_work.cp0;
        cp_last  = (r_idx == utf8_last_idx(cur_cp));
        cur_byte = utf8_byte(cur_cp, r_idx);
        // bare end marker when the descriptor carries no code point
        done     = !r_work.cp0_v || (cp_last && (r_sel || !r_work.cp1_v));
        load     = !i_q_empty && (!r_w_valid || (emit && done));
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_sel     <= 1'b0;
            r_idx     <= 2'd0;
        end else if (load) begin
            r_w_valid <= 1'b1;
            r_sel     <= 1'b0;
            r_idx     <= 2'd0;
        end else if (emit) begin
            if (done) begin
                r_w_valid <= 1'b0;
            end else if (cp_last) begin
                r_sel <= 1'b1;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_work <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_emit) begin
            r_out_valid <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte      <= r_work.cp0_v ? cur_byte : 8'd0;
            r_byte_valid    <= r_work.cp0_v;
            r_last_of_run   <= done;
            r_end_of_string <= done && r_work.ended;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_byte_valid;
    assign o_last_of_run   = r_last_of_run;
    assign o_end_of_string = r_end_of_string;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the UTF-16LE to UTF-8 transcoder unit.
`timescale 1ns / 1ps

module tb;
    import u16u8_pkg::*;

    typedef struct packed {
        logic [15:0] unit;
        logic        first;
        logic        last;
    } unit_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       run_end;
        logic       str_end;
    } utf8_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_code_unit = 16'h0000;
    logic        i_first_unit = 1'b0;
    logic        i_last_unit = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_last_of_run;
    logic        o_end_of_string;

    utf16le_to_utf8_transcoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_code_unit     (i_code_unit),
        .i_first_unit    (i_first_unit),
        .i_last_unit     (i_last_unit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string)
    );

    always #6 i_clk = ~i_clk;

    unit_item_t pending_units[$];
    utf8_beat_t utf8_expect_q[$];
    logic [7:0] enc_bytes[$];

    // transcoder state as the predictor sees it
    logic [9:0] held_bits = 10'h000;
    logic       held_hi = 1'b0;
    logic       stopped = 1'b0;

    int units_accepted = 0;
    int beats_seen = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic encode_cp(input logic [20:0] cp);
        if (cp <= 21'h00007F) begin
            enc_bytes.insert(enc_bytes.size(), cp[7:0]);
        end else if (cp <= 21'h0007FF) begin
            enc_bytes.insert(enc_bytes.size(), {3'b110, cp[10:6]});
            enc_bytes.insert(enc_bytes.size(), {2'b10, cp[5:0]});
        end else if (cp <= 21'h00FFFF) begin
            enc_bytes.insert(enc_bytes.size(), {4'b1110, cp[15:12]});
            enc_bytes.insert(enc_bytes.size(), {2'b10, cp[11:6]});
            enc_bytes.insert(enc_bytes.size(), {2'b10, cp[5:0]});
        end else begin
            enc_bytes.insert(enc_bytes.size(), {5'b11110, cp[20:18]});
            enc_bytes.insert(enc_bytes.size(), {2'b10, cp[17:12]});
            enc_bytes.insert(enc_bytes.size(), {2'b10, cp[11:6]});
            enc_bytes.insert(enc_bytes.size(), {2'b10, cp[5:0]});
        end
    endtask

    // Predict the UTF-8 beats that one accepted code unit produces.
    task automatic transcode_unit(input logic [15:0] unit, input logic first,
                                  input logic last);
        logic       ended;
        logic       is_low;
        logic       is_high;
        utf8_beat_t beat;
        int         k;
        ended = 1'b0;
        enc_bytes.delete();
        if (first) begin
            held_bits = 10'h000;
            held_hi = 1'b0;
            stopped = 1'b0;
        end
        if (!stopped) begin
            is_low = (unit >= UNIT_LOW_MIN) && (unit <= UNIT_LOW_MAX);
            is_high = (unit >= UNIT_HIGH_MIN) && (unit <= UNIT_HIGH_MAX);
            if (first && unit == UNIT_BOM) begin
                // byte-order mark dropped
            end else if (held_hi && is_low) begin
                encode_cp(CP_SUPP_BASE + {1'b0, held_bits, unit[9:0]});
                held_hi = 1'b0;
                held_bits = 10'h000;
            end else begin
                if (held_hi) begin
                    encode_cp(CP_REPLACEMENT);
                    held_hi = 1'b0;
                    held_bits = 10'h000;
                end
                if (unit == 16'h0000) begin
                    ended = 1'b1;
                end else if (is_high) begin
                    held_bits = unit[9:0];
                    held_hi = 1'b1;
                end else if (is_low) begin
                    encode_cp(CP_REPLACEMENT);
                end else begin
                    encode_cp({5'b00000, unit});
                end
            end
            if (last) begin
                if (held_hi) begin
                    encode_cp(CP_REPLACEMENT);
                    held_hi = 1'b0;
                    held_bits = 10'h000;
                end
                ended = 1'b1;
            end
            if (ended) stopped = 1'b1;
            if (enc_bytes.size() == 0) begin
                if (ended) begin
                    beat = '{data: 8'h00, bvalid: 1'b0, run_end: 1'b1, str_end: 1'b1};
                    utf8_expect_q.insert(utf8_expect_q.size(), beat);
                end
            end else begin
                for (k = 0; k < enc_bytes.size(); k++) begin
                    beat.data = enc_bytes[k];
                    beat.bvalid = 1'b1;
                    beat.run_end = (k == enc_bytes.size() - 1);
                    beat.str_end = (k == enc_bytes.size() - 1) && ended;
                    utf8_expect_q.insert(utf8_expect_q.size(), beat);
                end
            end
        end
    endtask

    task automatic add_unit(input logic [15:0] unit, input logic first, input logic last);
        pending_units.insert(pending_units.size(), '{unit: unit, first: first, last: last});
    endtask

    // Driver: offers queued code units, idling at random outside a quiet window.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                transcode_unit(i_code_unit, i_first_unit, i_last_unit);
                units_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_units.size() > 0 &&
                    ((units_accepted >= 60 && units_accepted < 100) ||
                     $urandom_range(99) >= 32)) begin
                    i_in_valid <= 1'b1;
                    i_code_unit <= pending_units[0].unit;
                    i_first_unit <= pending_units[0].first;
                    i_last_unit <= pending_units[0].last;
                    pending_units.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transaction and drives the receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                beats_seen++;
                if (utf8_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte=%02h bv=%0b lr=%0b es=%0b",
                        o_out_byte, o_byte_valid, o_last_of_run, o_end_of_string));
                end else begin
                    if (o_out_byte !== utf8_expect_q[0].data ||
                        o_byte_valid !== utf8_expect_q[0].bvalid ||
                        o_last_of_run !== utf8_expect_q[0].run_end ||
                        o_end_of_string !== utf8_expect_q[0].str_end) begin
                        report_mismatch($sformatf(
                            "beat %0d got byte=%02h bv=%0b lr=%0b es=%0b exp %02h %0b %0b %0b",
                            beats_seen, o_out_byte, o_byte_valid, o_last_of_run,
                            o_end_of_string, utf8_expect_q[0].data, utf8_expect_q[0].bvalid,
                            utf8_expect_q[0].run_end, utf8_expect_q[0].str_end));
                    end
                    utf8_expect_q.pop_front();
                end
            end
            // one long hold-off so the input side backs up
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && beats_seen >= 30) begin
                hold_done = 1'b1;
                hold_left = 100;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !(beats_seen >= 150 && beats_seen < 260) &&
                               ($urandom_range(99) < 32);
            end
        end
    end

    initial begin
        unit_item_t str_q[$];
        int         rand_items;
        int         n_chars;
        int         r;
        int         mode;
        int         j;
        logic [15:0] u;
        logic [9:0]  lo10;

        // directed part
        add_unit(UNIT_BOM, 1'b1, 1'b0);      // BOM on first unit: skipped
        add_unit(16'h0041, 1'b0, 1'b0);
        add_unit(16'h0000, 1'b0, 1'b0);      // terminator, no bytes
        add_unit(16'h0042, 1'b0, 1'b0);      // dropped after end
        add_unit(16'h0080, 1'b1, 1'b0);
        add_unit(16'h07FF, 1'b0, 1'b0);
        add_unit(16'h0800, 1'b0, 1'b0);
        add_unit(UNIT_BOM, 1'b0, 1'b0);      // BOM mid-string is a character
        add_unit(16'hFFFF, 1'b0, 1'b0);
        add_unit(16'hD800, 1'b0, 1'b0);
        add_unit(16'hDC00, 1'b0, 1'b0);
        add_unit(16'hDBFF, 1'b0, 1'b0);
        add_unit(16'hDFFF, 1'b0, 1'b0);
        add_unit(16'hDC00, 1'b0, 1'b0);      // lone low surrogate
        add_unit(16'hD83D, 1'b0, 1'b0);
        add_unit(16'h0041, 1'b0, 1'b0);      // high not followed by low
        add_unit(16'hD800, 1'b0, 1'b0);
        add_unit(16'h0000, 1'b0, 1'b0);      // terminator after held high
        add_unit(16'hD801, 1'b1, 1'b0);
        add_unit(16'h0001, 1'b1, 1'b0);      // first flag drops held high
        add_unit(16'hDBFF, 1'b0, 1'b1);      // held high flushed by last
        add_unit(16'hD800, 1'b1, 1'b0);
        add_unit(16'hFFFF, 1'b0, 1'b0);      // six bytes from one unit
        add_unit(UNIT_BOM, 1'b1, 1'b1);      // bare end marker
        add_unit(16'h0000, 1'b1, 1'b1);
        add_unit(16'hD800, 1'b1, 1'b1);

        // random part: mostly well-formed strings, some noise
        rand_items = 0;
        while (rand_items < 100) begin
            if ($urandom_range(99) < 80) begin
                str_q.delete();
                if ($urandom_range(3) == 0) str_q.insert(str_q.size(), '{UNIT_BOM, 1'b0, 1'b0});
                n_chars = $urandom_range(1, 8);
                for (j = 0; j < n_chars; j++) begin
                    r = $urandom_range(99);
                    lo10 = 10'($urandom_range(1023));
                    if (r < 25) begin
                        u = 16'($urandom_range(1, 127));
                        str_q.insert(str_q.size(), '{u, 1'b0, 1'b0});
                    end else if (r < 45) begin
                        u = 16'($urandom_range(16'h0080, 16'h07FF));
                        str_q.insert(str_q.size(), '{u, 1'b0, 1'b0});
                    end else if (r < 65) begin
                        u = 16'($urandom_range(16'h0800, 16'hFFFF));
                        if (u >= UNIT_HIGH_MIN && u <= UNIT_LOW_MAX) u = u ^ 16'h4000;
                        str_q.insert(str_q.size(), '{u, 1'b0, 1'b0});
                    end else if (r < 90) begin
                        str_q.insert(str_q.size(), '{UNIT_HIGH_MIN | {6'h00, lo10}, 1'b0, 1'b0});
                        lo10 = 10'($urandom_range(1023));
                        str_q.insert(str_q.size(), '{UNIT_LOW_MIN | {6'h00, lo10}, 1'b0, 1'b0});
                    end else if (r < 95) begin
                        str_q.insert(str_q.size(), '{UNIT_HIGH_MIN | {6'h00, lo10}, 1'b0, 1'b0});
                    end else begin
                        str_q.insert(str_q.size(), '{UNIT_LOW_MIN | {6'h00, lo10}, 1'b0, 1'b0});
                    end
                end
                str_q[0].first = 1'b1;
                mode = $urandom_range(9);
                if (mode < 4) begin
                    str_q.insert(str_q.size(), '{16'h0000, 1'b0, 1'b0});
                end else if (mode < 8) begin
                    str_q[str_q.size() - 1].last = 1'b1;
                end
                rand_items += str_q.size();
                foreach (str_q[s]) pending_units.insert(pending_units.size(), str_q[s]);
                // sometimes one unit follows a terminator and is simply dropped
                if (mode < 4 && $urandom_range(9) < 3) begin
                    add_unit(16'($urandom_range(16'hFFFF)), 1'b0, 1'b0);
                end
            end else begin
                n_chars = $urandom_range(1, 4);
                for (j = 0; j < n_chars; j++) begin
                    add_unit(16'($urandom_range(16'hFFFF)), $urandom_range(3) == 0,
                             $urandom_range(7) == 0);
                end
                rand_items += n_chars;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_units.size() != 0 || i_in_valid || utf8_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
